>>> hdl/jsu_pkg.sv
// Shared constants and types for the JSON string unescaper.
package jsu_pkg;

   localparam int BUFFER_DEPTH = 256;
   localparam int CAP_W        = 9;
   localparam int POS_W        = 9;
   localparam int MAX_BYTE_ROWS = 7;

   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_N      = 8'h6E;
   localparam logic [7:0] CH_R      = 8'h72;
   localparam logic [7:0] CH_T      = 8'h74;
   localparam logic [7:0] CH_B      = 8'h62;
   localparam logic [7:0] CH_F      = 8'h66;
   localparam logic [7:0] CH_U      = 8'h75;

   localparam logic KIND_BYTE = 1'b0;
   localparam logic KIND_LEN  = 1'b1;

   // One engine action handed to the result stage: up to four bytes or a length.
   typedef struct packed {
      logic            load;
      logic            is_len;
      logic [2:0]      cnt;
      logic [3:0][7:0] bytes;
      logic [7:0]      base;
      logic [7:0]      len;
   } grp_type;

endpackage

>>> hdl/jsu_ifs.sv
// Channel interfaces: byte request, result and capacity write.
interface jsu_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       is_last;
   modport source (output valid, output in_byte, output is_last, input ready);
   modport sink (input valid, input in_byte, input is_last, output ready);
endinterface

interface jsu_rsp_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [7:0] out_byte;
   logic [7:0] position;
   logic [7:0] final_length;
   logic       done_res;
   modport source (output valid, output kind, output out_byte, output position,
                   output final_length, output done_res, input ready);
   modport sink (input valid, input kind, input out_byte, input position,
                 input final_length, input done_res, output ready);
endinterface

interface jsu_csr_if;
   logic       valid;
   logic       ready;
   logic [8:0] data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

>>> hdl/jsu_engine.sv
// Unescape engine: one byte step per cycle while emit_room holds; replay queue for dropped escapes.
module jsu_engine (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [jsu_pkg::CAP_W-1:0] eff_cap,
   jsu_req_if.sink                 req,
   input  logic                    emit_room,
   output jsu_pkg::grp_type        grp
);
   import jsu_pkg::*;

   typedef enum logic [1:0] {PH_IDLE, PH_ESC, PH_HEX, PH_SUR} phase_type;

   typedef struct packed {
      logic [2:0]      n;
      logic [3:0][7:0] t;
   } cp_type;

   function automatic logic [4:0] hex_digit(input logic [7:0] c);
      logic [4:0] r;
      if (c >= 8'h30 && c <= 8'h39) r = {1'b0, 4'(c - 8'h30)};
      else if (c >= 8'h61 && c <= 8'h66) r = {1'b0, 4'(c - 8'h57)};
      else if (c >= 8'h41 && c <= 8'h46) r = {1'b0, 4'(c - 8'h37)};
      else r = 5'h10;
      return r;
   endfunction

   // bit 16 flags a bad digit
   function automatic logic [16:0] hex_word(input logic [3:0][7:0] p);
      logic [4:0]  d0, d1, d2, d3;
      d0 = hex_digit(p[0]);
      d1 = hex_digit(p[1]);
      d2 = hex_digit(p[2]);
      d3 = hex_digit(p[3]);
      return {d0[4] | d1[4] | d2[4] | d3[4], d0[3:0], d1[3:0], d2[3:0], d3[3:0]};
   endfunction

   function automatic cp_type encode(input logic [20:0] cp);
      cp_type r;
      r = '0;
      if (cp < 21'h80) begin
         r.n = 3'd1; r.t[0] = cp[7:0];
      end else if (cp < 21'h800) begin
         r.n = 3'd2;
         r.t[0] = 8'hC0 | {3'b0, cp[10:6]};
         r.t[1] = 8'h80 | {2'b0, cp[5:0]};
      end else if (cp < 21'h10000) begin
         r.n = 3'd3;
         r.t[0] = 8'hE0 | {4'b0, cp[15:12]};
         r.t[1] = 8'h80 | {2'b0, cp[11:6]};
         r.t[2] = 8'h80 | {2'b0, cp[5:0]};
      end else begin
         r.n = 3'd4;
         r.t[0] = 8'hF0 | {5'b0, cp[20:18]};
         r.t[1] = 8'h80 | {2'b0, cp[17:12]};
         r.t[2] = 8'h80 | {2'b0, cp[11:6]};
         r.t[3] = 8'h80 | {2'b0, cp[5:0]};
      end
      return r;
   endfunction

   // drop a partial trailing UTF-8 sequence
   function automatic logic [POS_W-1:0] trim_len(input logic [POS_W-1:0] p,
                                                 input logic [2:0][7:0] r);
      logic [POS_W-1:0] res;
      logic             stop;
      logic [2:0]       need;
      res = p;
      stop = 1'b0;
      need = 3'd0;
      for (int i = 0; i < 3; i++) begin
         if (!stop && POS_W'(i) < p && r[i][7:6] != 2'b10) begin
            stop = 1'b1;
            if (r[i][7] == 1'b0) need = 3'd1;
            else if (r[i][7:5] == 3'b110) need = 3'd2;
            else if (r[i][7:4] == 4'b1110) need = 3'd3;
            else if (r[i][7:3] == 5'b11110) need = 3'd4;
            else need = 3'd0;
            if (need > 3'(i + 1)) res = p - POS_W'(i) - POS_W'(1);
         end
      end
      return res;
   endfunction

   phase_type        phase_ff, phase_in;
   logic [5:0][7:0]  hold_ff, hold_in;
   logic [2:0]       hcnt_ff, hcnt_in;
   logic [15:0]      surr_ff, surr_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic             first_ff, first_in;
   logic             strip_ff, strip_in;
   logic             trunc_ff, trunc_in;
   logic [2:0][7:0]  recent_ff, recent_in;
   logic [7:0][7:0]  queue_ff, queue_in;
   logic [3:0]       qcnt_ff, qcnt_in;
   logic             fin_ff, fin_in;
   logic [2:0]       rows_ff, rows_in;

   logic             do_step, do_fail, do_len, pop, accept;
   logic [7:0]       step_c;
   logic [20:0]      cp_val;
   logic             put_en, one_en;
   logic [7:0]       one_b;
   logic [16:0]      hw;
   logic [3:0][7:0]  hex_src;
   cp_type           enc, wr;
   logic [7:0][7:0]  push_b, rest;
   logic [2:0]       push_n;
   logic [3:0]       rcnt;
   logic [2:0]       rows_base, room, e_cnt;
   logic [2:0][7:0]  rsh;
   logic [POS_W:0]   fit_sum;
   logic [POS_W-1:0] trim_p;

   assign req.ready = (qcnt_ff == 4'd0) && !fin_ff && emit_room;
   assign trim_p    = trim_len(pos_ff, recent_ff);

   always_comb begin
      phase_in  = phase_ff;
      hold_in   = hold_ff;
      hcnt_in   = hcnt_ff;
      surr_in   = surr_ff;
      pos_in    = pos_ff;
      first_in  = first_ff;
      strip_in  = strip_ff;
      trunc_in  = trunc_ff;
      recent_in = recent_ff;
      queue_in  = queue_ff;
      qcnt_in   = qcnt_ff;
      fin_in    = fin_ff;
      rows_in   = rows_ff;
      do_step   = 1'b0;
      do_fail   = 1'b0;
      do_len    = 1'b0;
      pop       = 1'b0;
      accept    = 1'b0;
      step_c    = queue_ff[0];
      cp_val    = '0;
      put_en    = 1'b0;
      one_en    = 1'b0;
      one_b     = '0;
      push_b    = '0;
      push_n    = 3'd0;
      hex_src   = '0;
      hw        = '0;
      grp       = '0;

      // pick the action: replay first, then finishing, then a new word
      if (emit_room) begin
         if (qcnt_ff != 4'd0) begin
            do_step = 1'b1;
            pop = 1'b1;
         end else if (fin_ff) begin
            if (!trunc_ff && phase_ff == PH_SUR) do_fail = 1'b1;
            else do_len = 1'b1;
         end else if (req.valid) begin
            accept = 1'b1;
            step_c = req.in_byte;
            if (req.is_last) fin_in = 1'b1;
            if (!first_ff) begin
               first_in = 1'b1;
               if (req.in_byte == CH_QUOTE && !req.is_last) strip_in = 1'b1;
               else if (!trunc_ff) do_step = 1'b1;
            end else if (!(req.is_last && strip_ff) && !trunc_ff) begin
               do_step = 1'b1;
            end
         end
      end
      rows_base = accept ? 3'd0 : rows_ff;

      if (do_step) begin
         case (phase_ff)
            PH_IDLE: begin
               if ({1'b0, pos_ff} + (POS_W+1)'(1) >= {1'b0, eff_cap}) trunc_in = 1'b1;
               else if (step_c != CH_BSLASH) begin
                  one_en = 1'b1; one_b = step_c;
               end else phase_in = PH_ESC;
            end
            PH_ESC: begin
               phase_in = PH_IDLE;
               one_en = 1'b1;
               case (step_c)
                  CH_N: one_b = 8'h0A;
                  CH_R: one_b = 8'h0D;
                  CH_T: one_b = 8'h09;
                  CH_B: one_b = 8'h08;
                  CH_F: one_b = 8'h0C;
                  CH_U: begin
                     one_en = 1'b0; phase_in = PH_HEX; hcnt_in = 3'd0;
                  end
                  default: one_b = step_c;
               endcase
            end
            PH_HEX: begin
               hold_in[hcnt_ff] = step_c;
               hcnt_in = hcnt_ff + 3'd1;
               if (hcnt_ff == 3'd3) begin
                  hex_src = {step_c, hold_ff[2], hold_ff[1], hold_ff[0]};
                  hw = hex_word(hex_src);
                  hcnt_in = 3'd0;
                  phase_in = PH_IDLE;
                  if (hw[16]) begin
                     push_b[5:0] = hold_in;
                     push_n = 3'd4;
                  end else if (hw[15:10] == 6'b110110) begin
                     surr_in = hw[15:0];
                     phase_in = PH_SUR;
                  end else begin
                     put_en = 1'b1; cp_val = {5'b0, hw[15:0]};
                  end
               end
            end
            default: begin
               hold_in[hcnt_ff] = step_c;
               hcnt_in = hcnt_ff + 3'd1;
               if ((hcnt_ff == 3'd0 && step_c != CH_BSLASH) ||
                   (hcnt_ff == 3'd1 && step_c != CH_U)) begin
                  do_fail = 1'b1;
                  push_b[5:0] = hold_in;
                  push_n = hcnt_ff + 3'd1;
               end else if (hcnt_ff == 3'd5) begin
                  hex_src = {step_c, hold_ff[4], hold_ff[3], hold_ff[2]};
                  hw = hex_word(hex_src);
                  if (!hw[16] && hw[15:10] == 6'b110111) begin
                     put_en = 1'b1;
                     cp_val = 21'h10000 + {1'b0, surr_ff[9:0], hw[9:0]};
                     phase_in = PH_IDLE;
                     hcnt_in = 3'd0;
                  end else begin
                     do_fail = 1'b1;
                     push_b[5:0] = hold_in;
                     push_n = 3'd6;
                  end
               end
            end
         endcase
      end else if (do_fail) begin
         push_b[5:0] = hold_ff;
         push_n = hcnt_ff;
      end

      // unpaired high surrogate: write it alone and replay what followed
      if (do_fail) begin
         put_en = 1'b1;
         cp_val = {5'b0, surr_ff};
         phase_in = PH_IDLE;
         hcnt_in = 3'd0;
      end

      enc = encode(cp_val);
      fit_sum = {1'b0, pos_ff} + (POS_W+1)'(enc.n) + (POS_W+1)'(1);
      wr = '0;
      if (one_en) begin
         wr.n = 3'd1; wr.t[0] = one_b;
      end else if (put_en && fit_sum <= {1'b0, eff_cap}) begin
         wr = enc;
      end

      // advance position and the last-three-bytes history
      pos_in = pos_ff + POS_W'(wr.n);
      rsh = recent_ff;
      for (int k = 0; k < 4; k++) begin
         if (3'(k) < wr.n) begin
            rsh[2] = rsh[1];
            rsh[1] = rsh[0];
            rsh[0] = wr.t[k];
         end
      end
      recent_in = rsh;

      room  = 3'(MAX_BYTE_ROWS) - rows_base;
      e_cnt = (wr.n <= room) ? wr.n : room;
      if (do_step || do_fail) rows_in = rows_base + e_cnt;
      else if (accept) rows_in = 3'd0;

      // replay queue: drop the head, put pushed bytes in front
      rest = queue_ff;
      if (pop) begin
         for (int i = 0; i < 7; i++) rest[i] = queue_ff[i + 1];
         rest[7] = '0;
      end
      rcnt = qcnt_ff - {3'b0, pop};
      for (int i = 0; i < 8; i++) begin
         if (3'(i) < push_n) queue_in[i] = push_b[i];
         else queue_in[i] = rest[3'(i) - push_n];
      end
      qcnt_in = rcnt + {1'b0, push_n};
      if (trunc_in) qcnt_in = 4'd0;

      if (do_step || do_fail) begin
         grp.load   = (e_cnt != 3'd0);
         grp.is_len = KIND_BYTE;
         grp.cnt    = e_cnt;
         grp.bytes  = wr.t;
         grp.base   = pos_ff[7:0];
      end

      if (do_len) begin
         grp.load   = 1'b1;
         grp.is_len = KIND_LEN;
         grp.cnt    = 3'd1;
         grp.len    = trunc_ff ? trim_p[7:0] : pos_ff[7:0];
         phase_in  = PH_IDLE;
         hcnt_in   = 3'd0;
         surr_in   = '0;
         pos_in    = '0;
         first_in  = 1'b0;
         strip_in  = 1'b0;
         trunc_in  = 1'b0;
         recent_in = '0;
         qcnt_in   = 4'd0;
         fin_in    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         hcnt_ff   <= '0;
         surr_ff   <= '0;
         pos_ff    <= '0;
         first_ff  <= 1'b0;
         strip_ff  <= 1'b0;
         trunc_ff  <= 1'b0;
         recent_ff <= '0;
         qcnt_ff   <= '0;
         fin_ff    <= 1'b0;
         rows_ff   <= '0;
      end else begin
         phase_ff  <= phase_in;
         hcnt_ff   <= hcnt_in;
         surr_ff   <= surr_in;
         pos_ff    <= pos_in;
         first_ff  <= first_in;
         strip_ff  <= strip_in;
         trunc_ff  <= trunc_in;
         recent_ff <= recent_in;
         qcnt_ff   <= qcnt_in;
         fin_ff    <= fin_in;
         rows_ff   <= rows_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_ff  <= hold_in;
      queue_ff <= queue_in;
   end

endmodule

>>> hdl/jsu_emit.sv
// Result stage: holds one engine action, hands it out one word per cycle while rsp.ready.
module jsu_emit (
   input  logic             clock,
   input  logic             reset,
   input  jsu_pkg::grp_type grp,
   output logic             emit_room,
   jsu_rsp_if.source        rsp
);
   import jsu_pkg::*;

   logic [2:0]      cnt_ff;
   logic            kind_ff;
   logic [3:0][7:0] bytes_ff;
   logic [7:0]      pos_ff;
   logic [7:0]      len_ff;
   logic            pop;

   assign pop       = rsp.valid && rsp.ready;
   assign emit_room = (cnt_ff == 3'd0) || (cnt_ff == 3'd1 && rsp.ready);

   assign rsp.valid        = (cnt_ff != 3'd0);
   assign rsp.kind         = kind_ff;
   assign rsp.out_byte     = (kind_ff == KIND_LEN) ? 8'h00 : bytes_ff[0];
   assign rsp.position     = (kind_ff == KIND_LEN) ? 8'h00 : pos_ff;
   assign rsp.final_length = (kind_ff == KIND_LEN) ? len_ff : 8'h00;
   assign rsp.done_res     = (kind_ff == KIND_LEN);

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (grp.load) begin
         cnt_ff <= grp.cnt;
      end else if (pop) begin
         cnt_ff <= cnt_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (grp.load) begin
         kind_ff  <= grp.is_len;
         bytes_ff <= grp.bytes;
         pos_ff   <= grp.base;
         len_ff   <= grp.len;
      end else if (pop) begin
         bytes_ff <= {8'h00, bytes_ff[3:1]};
         pos_ff   <= pos_ff + 8'd1;
      end
   end

endmodule

>>> hdl/json_string_unescape_utf8.sv
// Top level of the JSON string unescaper with UTF-8 output.
//
// Usage: feed the raw bytes of one JSON string value on req_ch, one word per
// accepted handshake, with is_last set on the final byte. Decoded bytes come
// out on rsp_ch as kind 0 words carrying the byte and its buffer position;
// the value ends with one kind 1 word carrying the final length and done_res.
// csr_ch writes the buffer capacity (terminator included); write it only
// while the block is idle. It resets to 256.
// A result word is registered and appears in the cycle after the byte that
// causes it. It takes one byte per cycle while each byte yields at most one
// word and rsp_ch does not stall. A \u escape of n bytes holds req_ch until
// the result stage is on its last byte; a dropped escape replays its held
// bytes through the step unit at one byte per cycle while the result stage
// has room; any unpaired surrogate replay and the length word follow is_last.
// Reset (synchronous, active high) clears all string state and the result
// stage. When rsp_ch stalls, the result register holds its word and req_ch
// keeps taking bytes only as long as the result stage can absorb them.
module json_string_unescape_utf8 (
   input logic      clock,
   input logic      reset,
   jsu_csr_if.sink  csr_ch,
   jsu_req_if.sink  req_ch,
   jsu_rsp_if.source rsp_ch
);
   import jsu_pkg::*;

   logic [CAP_W-1:0] cap_ff;
   logic [CAP_W-1:0] cap_in;
   logic [CAP_W-1:0] eff_cap;
   logic             emit_room;
   grp_type          grp;

   // capacity register: always ready, take the write when offered
   assign csr_ch.ready = 1'b1;
   assign cap_in = (csr_ch.valid && csr_ch.ready) ? csr_ch.data : cap_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CAP_W'(BUFFER_DEPTH);
      end else begin
         cap_ff <= cap_in;
      end
   end

   // clamp the capacity to the buffer depth
   assign eff_cap = (cap_ff > CAP_W'(BUFFER_DEPTH)) ? CAP_W'(BUFFER_DEPTH) : cap_ff;

   // step unit: decode escapes, track position, queue replays
   jsu_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .eff_cap   (eff_cap),
      .req       (req_ch),
      .emit_room (emit_room),
      .grp       (grp)
   );

   // result register: serialize each action into output words
   jsu_emit u_emit (
      .clock     (clock),
      .reset     (reset),
      .grp       (grp),
      .emit_room (emit_room),
      .rsp       (rsp_ch)
   );

endmodule
